// ----- src/diff_drive_odometry_top_defines.svh -----
// Assertion macros for the differential-drive odometry block.
`ifndef DIFF_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted.
`define DDO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define DDO_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDO_ASSERT(lbl, prop, msg)
`define DDO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/ddo_pkg.sv -----
// Package with constants and the arctangent table of the odometry block.
`timescale 1ns / 1ps
package ddo_pkg;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_ITERS_DEF = 24;
	localparam logic [9:0]  WB_RESET   = 10'd258;
	localparam logic [30:0] BAM_PER_PI = 31'd1367130551;
	localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

	// Arctangent of 2^-i in binary-angle units, full turn = 2^32.
	function automatic logic [31:0] atan_bam(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction
endpackage

// ----- src/ddo_if.sv -----
// Channel interfaces: odometry sample in, pose out.
`timescale 1ns / 1ps
interface ddo_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] turn_half_diff;
	logic signed [15:0] travel_mm;
	modport source (output valid, output turn_half_diff, output travel_mm, input ready);
	modport sink (input valid, input turn_half_diff, input travel_mm, output ready);
endinterface

interface ddo_pose_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic        [31:0] heading;
	modport source (output valid, output pos_x, output pos_y, output heading, input ready);
	modport sink (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

// ----- src/diff_drive_odometry_top.sv -----
// Top level of the differential-drive arc odometry block.
//
// The sample channel takes one beat per odometry sample (half wheel
// difference and mean travel, mm). The pose channel returns one beat per
// sample with x, y (mm, FRAC_BITS fraction bits) and heading (binary angle).
// cfg_we/cfg_wdata write the wheel base; write it only while idle.
// One shared restoring divider (57 quotient bits a pass), one iterative CORDIC
// (CORDIC_ITERS rotations a pass) and a two-pass multiplier run in sequence.
// No movement goes straight to the output register; a turn on the spot
// takes one divider pass; a straight move one CORDIC pass and the multiplier;
// an arc two divider passes, two CORDIC passes and the multiplier.
// One sample is in work at a time; ready is high only when the sequencer
// is idle, which it is again right after the pose is loaded.
// The sequencer loads the output register once it is free, so a stalled
// receiver holds the next pose at its last step while the current one waits.
// Reset clears the pose to zero and the wheel base to 258 mm.
`timescale 1ns / 1ps
`include "diff_drive_odometry_top_defines.svh"
module diff_drive_odometry_top
	import ddo_pkg::*;
#(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata,
	ddo_sample_if.sink sample,
	ddo_pose_if.source pose
);
	localparam int SH    = 60 - FRAC_BITS;
	localparam int ACC_W = SH + 48;
	localparam int DW    = 57;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MULT, ST_DIV1, ST_CORD1, ST_MUL2, ST_DIV2, ST_CORD2, ST_MPY, ST_DONE
	} state_t;

	state_t             state_q;
	logic        [9:0]  wb_cfg_q, wb_q;
	logic signed [15:0] turn_q, travel_q;
	logic signed [47:0] x_q, y_q;
	logic        [31:0] hd_q, theta_q, half_q;
	logic        [DW-1:0] dvd_q, chord_mag_q;
	logic        [15:0] dvs_q, rem_q;
	logic        [5:0]  cnt_q;
	logic signed [26:0] tw_q;
	logic signed [33:0] cx_q, cy_q, cz_q, sin_q, cos_q;
	logic               flip_q, chord_neg_q;
	logic [ACC_W-1:0]   acc_q;
	logic               out_valid_q;
	logic signed [47:0] out_x_q, out_y_q;
	logic        [31:0] out_hd_q;

	// Divider step: shift one dividend bit into the remainder.
	logic [16:0]   rem_sh;
	logic          div_ge;
	logic [15:0]   rem_n;
	logic [DW-1:0] dvd_n;
	always_comb begin
		rem_sh = {rem_q, dvd_q[DW-1]};
		div_ge = rem_sh >= {1'b0, dvs_q};
		rem_n  = div_ge ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
		dvd_n  = {dvd_q[DW-2:0], div_ge};
	end

	// CORDIC rotation step.
	logic        [4:0]  ci;
	logic signed [33:0] cdx, cdy, ca, cx_n, cy_n, cz_n;
	always_comb begin
		ci  = cnt_q[4:0];
		cdx = cy_q >>> ci;
		cdy = cx_q >>> ci;
		ca  = 34'(atan_bam(ci));
		if (!cz_q[33]) begin
			cx_n = cx_q - cdx;
			cy_n = cy_q + cdy;
			cz_n = cz_q - ca;
		end else begin
			cx_n = cx_q + cdx;
			cy_n = cy_q - cdy;
			cz_n = cz_q + ca;
		end
	end

	// Input magnitudes and sample products.
	logic [15:0]        tmag, vmag;
	logic [46:0]        tprod;
	logic signed [26:0] tw_n;
	logic signed [60:0] p2;
	logic [60:0]        p2mag;
	always_comb begin
		tmag  = turn_q[15] ? 16'(-turn_q) : 16'(turn_q);
		vmag  = travel_q[15] ? 16'(-travel_q) : 16'(travel_q);
		tprod = 47'(tmag) * 47'(BAM_PER_PI);
		tw_n  = 27'(travel_q) * 27'($signed({1'b0, wb_q}));
		p2    = 61'(tw_q) * 61'(sin_q);
		p2mag = p2[60] ? 61'(-p2) : 61'(p2);
	end

	// Partial products of the chord with cos or sin.
	logic [33:0] bsel;
	logic [31:0] bmag;
	logic [28:0] apart;
	logic [60:0] pp;
	logic [47:0] step_r, step_v;
	logic        step_neg;
	always_comb begin
		bsel     = (cnt_q < 6'd2) ? cos_q : sin_q;
		bmag     = bsel[33] ? 32'(-$signed(bsel)) : bsel[31:0];
		apart    = (cnt_q[0] == 1'b0) ? chord_mag_q[28:0] : {1'b0, chord_mag_q[DW-1:29]};
		pp       = 61'(apart) * 61'(bmag);
		step_neg = chord_neg_q ^ ((cnt_q == 6'd2) ? cos_q[33] : sin_q[33]);
		step_r   = acc_q[SH +: 48];
		step_v   = step_neg ? 48'(-step_r) : step_r;
	end

	// Fold of a CORDIC start angle to the right half plane.
	function automatic logic [32:0] fold_ang(input logic [31:0] ang);
		logic [31:0] t;
		t = ang + 32'h40000000;
		return {t[31], ang ^ {t[31], 31'b0}};
	endfunction

	logic [32:0] fa_dir, fa_hd;
	assign fa_dir  = fold_ang(hd_q + half_q);
	assign fa_hd   = fold_ang(hd_q);

	logic [31:0] q_theta, q_half;
	assign q_theta = turn_q[15] ? 32'(-dvd_n[31:0]) : dvd_n[31:0];
	assign q_half  = turn_q[15] ? 32'(-dvd_n[32:1]) : dvd_n[32:1];
	logic [32:0] fa_h;
	assign fa_h = fold_ang(q_half);

	// Sequencer, pose state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wb_cfg_q    <= WB_RESET;
			x_q         <= '0;
			y_q         <= '0;
			hd_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) wb_cfg_q <= cfg_wdata;
			if (pose.valid && pose.ready && state_q != ST_DONE) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						turn_q   <= sample.turn_half_diff;
						travel_q <= sample.travel_mm;
						wb_q     <= (wb_cfg_q == 10'd0) ? 10'd1 : wb_cfg_q;
						state_q  <= ST_MULT;
					end
				end
				ST_MULT: begin
					tw_q  <= tw_n;
					dvd_q <= DW'(tprod);
					dvs_q <= {6'b0, wb_q};
					rem_q <= '0;
					cnt_q <= '0;
					if (turn_q == 16'sd0) begin
						if (travel_q == 16'sd0) begin
							state_q <= ST_DONE;
						end else begin
							chord_mag_q <= DW'({vmag, 30'b0});
							chord_neg_q <= travel_q[15];
							flip_q      <= fa_hd[32];
							cx_q        <= CORDIC_GAIN;
							cy_q        <= '0;
							cz_q        <= 34'($signed(fa_hd[31:0]));
							state_q     <= ST_CORD2;
						end
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1, ST_DIV2: begin
					dvd_q <= dvd_n;
					rem_q <= rem_n;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DW - 1)) begin
						cnt_q <= '0;
						if (state_q == ST_DIV1) begin
							theta_q <= q_theta;
							half_q  <= q_half;
							if (travel_q == 16'sd0) begin
								hd_q    <= hd_q + q_theta;
								state_q <= ST_DONE;
							end else begin
								flip_q  <= fa_h[32];
								cx_q    <= CORDIC_GAIN;
								cy_q    <= '0;
								cz_q    <= 34'($signed(fa_h[31:0]));
								state_q <= ST_CORD1;
							end
						end else begin
							chord_mag_q <= dvd_n;
							flip_q      <= fa_dir[32];
							cx_q        <= CORDIC_GAIN;
							cy_q        <= '0;
							cz_q        <= 34'($signed(fa_dir[31:0]));
							state_q     <= ST_CORD2;
						end
					end
				end
				ST_CORD1, ST_CORD2: begin
					cx_q  <= cx_n;
					cy_q  <= cy_n;
					cz_q  <= cz_n;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(CORDIC_ITERS - 1)) begin
						cnt_q <= '0;
						sin_q <= flip_q ? -cy_n : cy_n;
						cos_q <= flip_q ? -cx_n : cx_n;
						state_q <= (state_q == ST_CORD1) ? ST_MUL2 : ST_MPY;
					end
				end
				ST_MUL2: begin
					dvd_q       <= p2mag[DW-1:0];
					dvs_q       <= tmag;
					rem_q       <= '0;
					cnt_q       <= '0;
					chord_neg_q <= p2[60] ^ turn_q[15];
					state_q     <= ST_DIV2;
				end
				ST_MPY: begin
					cnt_q <= cnt_q + 6'd1;
					case (cnt_q[2:0])
						3'd0: acc_q <= ACC_W'(pp);
						3'd1: acc_q <= acc_q + ACC_W'({pp, 29'b0});
						3'd2: begin
							x_q   <= x_q + $signed(step_v);
							acc_q <= ACC_W'(pp);
						end
						3'd3: acc_q <= acc_q + ACC_W'({pp, 29'b0});
						default: begin
							y_q     <= y_q + $signed(step_v);
							if (turn_q != 16'sd0) hd_q <= hd_q + theta_q;
							cnt_q   <= '0;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: begin
					if (!out_valid_q || pose.ready) begin
						out_x_q     <= x_q;
						out_y_q     <= y_q;
						out_hd_q    <= hd_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign pose.valid   = out_valid_q;
	assign pose.pos_x   = out_x_q;
	assign pose.pos_y   = out_y_q;
	assign pose.heading = out_hd_q;

	// A sample beat starts work, so ready drops in the next cycle.
	`DDO_ASSERT(a_busy_after_beat, (sample.valid && sample.ready) |=> !sample.ready, "ready after beat")
	// A pose appears only when the sequencer finishes.
	`DDO_ASSERT(a_pose_from_done, $rose(pose.valid) |-> $past(state_q) == ST_DONE, "stray pose")
	// A stalled pose stays offered.
	`DDO_ASSERT(a_pose_held, (pose.valid && !pose.ready) |=> pose.valid, "pose dropped")
	// Nothing is offered after a reset edge.
	`DDO_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !pose.valid, "pose in reset")
endmodule
